// ----- hw/rtl/jdp_pkg.sv -----
// jdp_pkg: widths, angle constants, arctangent table and the pipeline word type
// shared by the stick conditioning / polar conversion pipeline. no dependencies.
`timescale 1ns / 1ps

package jdp_pkg;

	localparam int AXIS_W       = 16;
	localparam int DZ_W         = 15;
	localparam int SQ_W         = 30;
	localparam int REM_W        = 31;
	localparam int ROOT_W       = 32;
	localparam int CX_W         = 26;
	localparam int Z_W          = 24;
	localparam int ZC_W         = 22;
	localparam int ANG_W        = 24;
	localparam int CORDIC_STEPS = 16;

	localparam logic [DZ_W-1:0]  DEAD_ZONE_RST  = 15'd4000;
	localparam logic [ANG_W-1:0] DEG90          = 24'd2949120;
	localparam logic [ANG_W-1:0] DEG180         = 24'd5898240;
	localparam logic [ANG_W-1:0] DEG360         = 24'd11796480;
	localparam logic [ANG_W-1:0] ANGLE_HALF_LSB = 24'd128;
	localparam logic [15:0]      ANGLE_WRAP     = 16'd46080;

	// atan(2^-i) in 1/32768 degree
	localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473,
		24'sd117189,  24'sd58652,  24'sd29333,  24'sd14667,
		24'sd7334,    24'sd3667,   24'sd1833,   24'sd917,
		24'sd458,     24'sd229,    24'sd115,    24'sd57
	};

	typedef struct packed {
		logic                     stick;
		logic signed [AXIS_W-1:0] x_norm;
		logic signed [AXIS_W-1:0] y_norm;
		logic [REM_W-1:0]         rem;
		logic [ROOT_W-1:0]        root;
		logic signed [CX_W-1:0]   cx;
		logic signed [CX_W-1:0]   cy;
		logic signed [Z_W-1:0]    z;
	} jdp_iter_t;

endpackage

// ----- hw/rtl/jdp_if.sv -----
// jdp_if: valid/ready channels for stick samples and polar results.
// depends on jdp_pkg for the field widths.
`timescale 1ns / 1ps

interface jdp_in_if;
	import jdp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     stick_index;
	logic signed [AXIS_W-1:0] x_raw;
	logic signed [AXIS_W-1:0] y_raw;

	modport source (output valid, stick_index, x_raw, y_raw, input ready);
	modport sink (input valid, stick_index, x_raw, y_raw, output ready);
endinterface

interface jdp_out_if;
	import jdp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     stick_out;
	logic signed [AXIS_W-1:0] x_norm;
	logic signed [AXIS_W-1:0] y_norm;
	logic [15:0]              magnitude;
	logic [15:0]              angle;

	modport source (output valid, stick_out, x_norm, y_norm, magnitude, angle, input ready);
	modport sink (input valid, stick_out, x_norm, y_norm, magnitude, angle, output ready);
endinterface

// ----- hw/rtl/joystick_deadzone_polar.sv -----
// joystick_deadzone_polar: top level, dead zone register and pipeline hookup.
// depends on jdp_pkg, jdp_if, jdp_front, jdp_iter, jdp_back.
//
//   port      dir   handshake      carries
//   sample    in    valid/ready    stick_index, x_raw, y_raw
//   result    out   valid/ready    stick_out, x_norm, y_norm, magnitude, angle
//   cfg       in    cfg_we         dead_zone (15 bit)
//
// 21 register stages: 3 front, 16 root/cordic steps, 2 back.
// one word in and one word out per cycle while the output is not stalled; the 16 cordic rotations set the depth.
// a stalled output freezes every stage at once, so nothing is dropped or repeated.
// reset clears the valid bits and loads the dead zone with 4000.
`timescale 1ns / 1ps

module joystick_deadzone_polar (
	input  logic                           clk,
	input  logic                           arst_n,
	jdp_in_if.sink                         sample,
	jdp_out_if.source                      result,
	input  logic                           cfg_we,
	input  logic [jdp_pkg::DZ_W-1:0]       cfg_wdata
);
	import jdp_pkg::*;

	logic            advance;
	logic [DZ_W-1:0] dead_zone_q;
	logic            front_vld;
	jdp_iter_t       front_data;
	logic            iter_vld;
	jdp_iter_t       iter_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= DEAD_ZONE_RST;
		end else if (cfg_we) begin
			dead_zone_q <= cfg_wdata;
		end
	end

	// whole pipe moves unless a finished word is held at the output
	assign advance      = !result.valid || result.ready;
	assign sample.ready = advance;

	jdp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_vld      (sample.valid),
		.stick_index (sample.stick_index),
		.x_raw       (sample.x_raw),
		.y_raw       (sample.y_raw),
		.dead_zone   (dead_zone_q),
		.out_vld     (front_vld),
		.out_data    (front_data)
	);

	jdp_iter u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_vld   (front_vld),
		.in_data  (front_data),
		.out_vld  (iter_vld),
		.out_data (iter_data)
	);

	jdp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_vld  (iter_vld),
		.in_data (iter_data),
		.result  (result)
	);

endmodule

// ----- hw/rtl/jdp_front.sv -----
// jdp_front: dead zone and clamp, squares, sum of squares and cordic seed
// (stages 1 to 3). depends on jdp_pkg.
`timescale 1ns / 1ps

module jdp_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              in_vld,
	input  logic                              stick_index,
	input  logic signed [jdp_pkg::AXIS_W-1:0] x_raw,
	input  logic signed [jdp_pkg::AXIS_W-1:0] y_raw,
	input  logic [jdp_pkg::DZ_W-1:0]          dead_zone,
	output logic                              out_vld,
	output jdp_pkg::jdp_iter_t                out_data
);
	import jdp_pkg::*;

	function automatic logic signed [AXIS_W-1:0] cond_axis(
		input logic signed [AXIS_W-1:0] v,
		input logic [DZ_W-1:0]          dz
	);
		logic signed [AXIS_W:0] vs;
		logic signed [AXIS_W:0] dzs;
		logic signed [AXIS_W-1:0] r;
		vs  = {v[AXIS_W-1], v};
		dzs = signed'({2'b00, dz});
		r   = '0;
		if (vs > dzs || vs < -dzs) begin
			// most negative reading clamps to -full scale
			if (v == {1'b1, {(AXIS_W-1){1'b0}}}) begin
				r = {1'b1, {(AXIS_W-2){1'b0}}, 1'b1};
			end else begin
				r = v;
			end
		end
		return r;
	endfunction

	logic signed [AXIS_W-1:0] xc;
	logic signed [AXIS_W-1:0] yc;
	logic [AXIS_W-1:0]        xa;
	logic [AXIS_W-1:0]        ya;

	logic                     vld_s1;
	logic                     stick_s1;
	logic signed [AXIS_W-1:0] xn_s1;
	logic signed [AXIS_W-1:0] yn_s1;
	logic [DZ_W-1:0]          ax_s1;
	logic [DZ_W-1:0]          ay_s1;

	logic                     vld_s2;
	logic                     stick_s2;
	logic signed [AXIS_W-1:0] xn_s2;
	logic signed [AXIS_W-1:0] yn_s2;
	logic [SQ_W-1:0]          sqx_s2;
	logic [SQ_W-1:0]          sqy_s2;
	logic signed [CX_W-1:0]   cx_s2;
	logic signed [CX_W-1:0]   cy_s2;

	logic                     vld_s3;
	jdp_iter_t                data_s3;

	assign xc = cond_axis(x_raw, dead_zone);
	assign yc = cond_axis(y_raw, dead_zone);
	assign xa = xc[AXIS_W-1] ? AXIS_W'(-xc) : AXIS_W'(xc);
	assign ya = yc[AXIS_W-1] ? AXIS_W'(-yc) : AXIS_W'(yc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stick_s1 <= stick_index;
			xn_s1    <= xc;
			yn_s1    <= yc;
			ax_s1    <= xa[DZ_W-1:0];
			ay_s1    <= ya[DZ_W-1:0];

			stick_s2 <= stick_s1;
			xn_s2    <= xn_s1;
			yn_s2    <= yn_s1;
			sqx_s2   <= {{(SQ_W-DZ_W){1'b0}}, ax_s1} * {{(SQ_W-DZ_W){1'b0}}, ax_s1};
			sqy_s2   <= {{(SQ_W-DZ_W){1'b0}}, ay_s1} * {{(SQ_W-DZ_W){1'b0}}, ay_s1};
			// cordic works on |x|, |y| scaled by 256
			cx_s2    <= signed'({{(CX_W-DZ_W-8){1'b0}}, ax_s1, 8'b0});
			cy_s2    <= signed'({{(CX_W-DZ_W-8){1'b0}}, ay_s1, 8'b0});

			data_s3.stick  <= stick_s2;
			data_s3.x_norm <= xn_s2;
			data_s3.y_norm <= yn_s2;
			data_s3.rem    <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			data_s3.root   <= '0;
			data_s3.cx     <= cx_s2;
			data_s3.cy     <= cy_s2;
			data_s3.z      <= '0;
		end
	end

	assign out_vld  = vld_s3;
	assign out_data = data_s3;

endmodule

// ----- hw/rtl/jdp_iter.sv -----
// jdp_iter: sixteen pipeline stages, each one square root digit and one
// vectoring cordic rotation. depends on jdp_pkg.
`timescale 1ns / 1ps

module jdp_iter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               in_vld,
	input  jdp_pkg::jdp_iter_t in_data,
	output logic               out_vld,
	output jdp_pkg::jdp_iter_t out_data
);
	import jdp_pkg::*;

	jdp_iter_t step_s [CORDIC_STEPS];
	logic      vld_s  [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		localparam logic [ROOT_W-1:0] SQ_BIT = ROOT_W'(1) << (2 * (CORDIC_STEPS - 1 - k));

		jdp_iter_t              prev;
		logic                   prev_vld;
		jdp_iter_t              nxt;
		logic [ROOT_W-1:0]      trial;
		logic signed [CX_W-1:0] dx;
		logic signed [CX_W-1:0] dy;

		if (k == 0) begin : g_head
			assign prev     = in_data;
			assign prev_vld = in_vld;
		end else begin : g_body
			assign prev     = step_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		assign trial = prev.root + SQ_BIT;
		assign dx    = prev.cy >>> k;
		assign dy    = prev.cx >>> k;

		always_comb begin
			nxt = prev;
			if ({1'b0, prev.rem} >= trial) begin
				nxt.rem  = prev.rem - trial[REM_W-1:0];
				nxt.root = (prev.root >> 1) + SQ_BIT;
			end else begin
				nxt.root = prev.root >> 1;
			end
			// rotate toward the x axis
			if (prev.cy > 0) begin
				nxt.cx = prev.cx + dx;
				nxt.cy = prev.cy - dy;
				nxt.z  = prev.z + ATAN_TAB[k];
			end else begin
				nxt.cx = prev.cx - dx;
				nxt.cy = prev.cy + dy;
				nxt.z  = prev.z - ATAN_TAB[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (advance) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				step_s[k] <= nxt;
			end
		end
	end

	assign out_vld  = vld_s[CORDIC_STEPS-1];
	assign out_data = step_s[CORDIC_STEPS-1];

endmodule

// ----- hw/rtl/jdp_back.sv -----
// jdp_back: root rounding, angle clamp and quadrant fold, 1/128 degree
// rounding and the output register (stages 20 and 21). depends on jdp_pkg, jdp_if.
`timescale 1ns / 1ps

module jdp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               in_vld,
	input  jdp_pkg::jdp_iter_t in_data,
	jdp_out_if.source          result
);
	import jdp_pkg::*;

	logic [ZC_W-1:0]  zc;
	logic [ANG_W-1:0] zx;
	logic [ANG_W-1:0] quad;
	logic             root_up;
	logic [ANG_W-1:0] rnd;
	logic [15:0]      ang;

	logic                     vld_s20;
	logic                     stick_s20;
	logic signed [AXIS_W-1:0] xn_s20;
	logic signed [AXIS_W-1:0] yn_s20;
	logic [15:0]              mag_s20;
	logic [ANG_W-1:0]         ang_s20;

	logic                     vld_s21;
	logic                     stick_s21;
	logic signed [AXIS_W-1:0] xn_s21;
	logic signed [AXIS_W-1:0] yn_s21;
	logic [15:0]              mag_s21;
	logic [15:0]              ang_s21;

	always_comb begin
		if (in_data.z[Z_W-1]) begin
			zc = '0;
		end else if (in_data.z[Z_W-2:0] > DEG90[Z_W-2:0]) begin
			zc = DEG90[ZC_W-1:0];
		end else begin
			zc = in_data.z[ZC_W-1:0];
		end
		zx = {{(ANG_W-ZC_W){1'b0}}, zc};
		unique case ({in_data.x_norm[AXIS_W-1], in_data.y_norm[AXIS_W-1]})
			2'b00:   quad = zx;
			2'b10:   quad = DEG180 - zx;
			2'b11:   quad = DEG180 + zx;
			default: quad = DEG360 - zx;
		endcase
		// zero vector points at angle zero
		if (in_data.x_norm == '0 && in_data.y_norm == '0) begin
			quad = '0;
		end
	end

	assign root_up = {1'b0, in_data.rem} > in_data.root;
	assign rnd     = ang_s20 + ANGLE_HALF_LSB;
	assign ang     = rnd[ANG_W-1:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
		end else if (advance) begin
			vld_s20 <= in_vld;
			vld_s21 <= vld_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stick_s20 <= in_data.stick;
			xn_s20    <= in_data.x_norm;
			yn_s20    <= in_data.y_norm;
			mag_s20   <= in_data.root[15:0] + {15'b0, root_up};
			ang_s20   <= quad;

			stick_s21 <= stick_s20;
			xn_s21    <= xn_s20;
			yn_s21    <= yn_s20;
			mag_s21   <= mag_s20;
			ang_s21   <= (ang == ANGLE_WRAP) ? '0 : ang;
		end
	end

	assign result.valid     = vld_s21;
	assign result.stick_out = stick_s21;
	assign result.x_norm    = xn_s21;
	assign result.y_norm    = yn_s21;
	assign result.magnitude = mag_s21;
	assign result.angle     = ang_s21;

endmodule
